>>> rtl/lnw_pkg.sv
// lnw_pkg: shared types, codes and the init command table for the lcd nibble writer
// no dependencies
`default_nettype none

package lnw_pkg;

	localparam int BIN_W   = 32;
	localparam int DIGITS  = 10;
	localparam int BCD_W   = 4 * DIGITS;
	localparam int CNT_W   = $clog2(BIN_W + 1);
	localparam int DIG_W   = $clog2(DIGITS + 1);

	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;
	localparam logic [7:0] CHAR_ZERO = 8'd48;

	typedef enum logic [1:0] {
		ACT_CMD  = 2'd0,
		ACT_DATA = 2'd1,
		ACT_INT  = 2'd2,
		ACT_INIT = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_HI,
		ST_LO
	} state_t;

	typedef struct packed {
		act_t               action;
		logic [7:0]         byte_value;
		logic signed [31:0] number;
	} cmd_t;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       last;
	} res_t;

	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] b;
		unique case (idx)
			2'd0: b = 8'h02;
			2'd1: b = 8'h28;
			2'd2: b = 8'h0e;
			default: b = 8'h01;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lnw_dabble.sv
// lnw_dabble: bit-serial binary to bcd converter, one input bit per cycle (shift and add 3)
// depends on lnw_pkg
`default_nettype none

module lnw_dabble import lnw_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire logic [BIN_W-1:0] mag,
	output logic                  done,
	output logic [BCD_W-1:0]      bcd
);

	logic [BIN_W-1:0] sr_q;
	logic [BCD_W-1:0] bcd_q;
	logic [BCD_W-1:0] adj;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(BIN_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			sr_q  <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			sr_q  <= {sr_q[BIN_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], sr_q[BIN_W-1]};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

`default_nettype wire

>>> rtl/lcd_nibble_writer_with_int_print_top.sv
// lcd_nibble_writer_with_int_print_top: request sequencer that splits bytes into nibbles
// depends on lnw_pkg and lnw_dabble
//
//   channel   handshake        payload
//   request   start / busy     cmd   (cmd_t: action, byte_value, number)
//   result    strobe           res   (res_t: nibble, reg_select, last)
//
// a request is taken when start is high and busy is low; busy stays high until the
// last nibble has been shown. one nibble per cycle once bytes flow. command and data
// bytes are sent high nibble then low nibble, init sends the four bytes of init_byte, and
// a nonzero integer runs serial bcd conversion, then leading zero skip, then its bytes.
// the receiver cannot stall: each nibble is shown for exactly one cycle. reset returns to idle.
`default_nettype none

module lcd_nibble_writer_with_int_print_top import lnw_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      strobe,
	output res_t      res
);

	state_t           state_q, state_d;
	act_t             mode_q;
	logic [7:0]       byte_q;
	logic             rs_q;
	logic             sign_q;
	logic [1:0]       idx_q;
	logic [DIG_W-1:0] dig_q;
	logic [BCD_W-1:0] bcd_q;

	logic             take;
	logic             is_neg;
	logic [BIN_W-1:0] mag;
	logic             dab_go;
	logic             dab_done;
	logic [BCD_W-1:0] dab_bcd;
	logic [3:0]       top_dig;
	logic             has_next;

	assign take    = start && (state_q == ST_IDLE);
	assign is_neg  = cmd.number[BIN_W-1];
	assign mag     = is_neg ? (BIN_W'(0) - BIN_W'(cmd.number)) : BIN_W'(cmd.number);
	assign dab_go  = take && (cmd.action == ACT_INT) && (cmd.number != '0);
	assign top_dig = bcd_q[BCD_W-1 -: 4];
	assign has_next = ((mode_q == ACT_INIT) && (idx_q != 2'd3)) ||
		((mode_q == ACT_INT) && (dig_q != '0));

	lnw_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (dab_go),
		.mag    (mag),
		.done   (dab_done),
		.bcd    (dab_bcd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					state_d = dab_go ? ST_CONV : ST_HI;
				end
			end
			ST_CONV: begin
				if (dab_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (top_dig != 4'd0) begin
					state_d = ST_HI;
				end
			end
			ST_HI: state_d = ST_LO;
			ST_LO: state_d = has_next ? ST_HI : ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy           = (state_q != ST_IDLE);
		strobe         = (state_q == ST_HI) || (state_q == ST_LO);
		res.nibble     = (state_q == ST_HI) ? byte_q[7:4] : byte_q[3:0];
		res.reg_select = rs_q;
		res.last       = (state_q == ST_LO) && !has_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					mode_q <= cmd.action;
					sign_q <= is_neg;
					idx_q  <= 2'd0;
					dig_q  <= '0;
					unique case (cmd.action)
						ACT_CMD: begin
							byte_q <= cmd.byte_value;
							rs_q   <= 1'b0;
						end
						ACT_DATA: begin
							byte_q <= cmd.byte_value;
							rs_q   <= 1'b1;
						end
						ACT_INT: begin
							byte_q <= CHAR_ZERO;
							rs_q   <= 1'b1;
						end
						default: begin
							byte_q <= init_byte(2'd0);
							rs_q   <= 1'b0;
						end
					endcase
				end
			end
			ST_CONV: begin
				if (dab_done) begin
					bcd_q <= dab_bcd;
					dig_q <= DIG_W'(DIGITS);
				end
			end
			ST_SKIP: begin
				if (top_dig == 4'd0) begin
					bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
					dig_q <= dig_q - 1'b1;
				end else if (sign_q) begin
					byte_q <= CHAR_MINUS;
					sign_q <= 1'b0;
				end else begin
					byte_q <= {CHAR_DIGIT_HI, top_dig};
					bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
					dig_q  <= dig_q - 1'b1;
				end
			end
			ST_LO: begin
				if (has_next) begin
					if (mode_q == ACT_INIT) begin
						idx_q  <= idx_q + 1'b1;
						byte_q <= init_byte(idx_q + 1'b1);
					end else begin
						byte_q <= {CHAR_DIGIT_HI, top_dig};
						bcd_q  <= {bcd_q[BCD_W-5:0], 4'd0};
						dig_q  <= dig_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
